// ===== rtl/ccfre_pkg.sv =====
`timescale 1ns / 1ps
// Package for the CIGAR clip-folding run encoder: sizes, op characters, opcodes
// and the packed beat types of both channels. It depends on nothing else.
package ccfre_pkg;

  // Capacity of the op store and the widths that follow from it.
  localparam int unsigned MAX_OPS = 4096;
  localparam int unsigned ADDR_W  = $clog2(MAX_OPS);
  // One more bit so that a counter can hold MAX_OPS itself.
  localparam int unsigned CNT_W   = ADDR_W + 1;

  localparam int unsigned OP_W        = 8;
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned RUN_COUNT_W = 13;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  // Register index taken from the word address bits of paddr.
  localparam logic [PADDR_W-3:0] REG_SIMPLIFY = '0;

  // ASCII op characters.
  localparam logic [OP_W-1:0] OP_SOFT = 8'h53; // S
  localparam logic [OP_W-1:0] OP_INS  = 8'h49; // I
  localparam logic [OP_W-1:0] OP_MISM = 8'h58; // X
  localparam logic [OP_W-1:0] OP_SEQM = 8'h3D; // =
  localparam logic [OP_W-1:0] OP_ALNM = 8'h4D; // M
  localparam logic [OP_W-1:0] OP_STAR = 8'h2A; // *

  typedef enum logic [OPCODE_W-1:0] {
    OPC_PUSH = 2'd0,
    OPC_END  = 2'd1,
    OPC_PULL = 2'd2,
    OPC_NONE = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [OP_W-1:0]     op_char;
  } in_beat_t;

  typedef struct packed {
    logic                   run_valid;
    logic [RUN_COUNT_W-1:0] run_count;
    logic [OP_W-1:0]        run_op;
    logic                   last_run;
    logic                   empty_record;
    logic                   overflow;
  } out_beat_t;

  // True for the ops that a clip region may fold in after its soft clips.
  function automatic logic is_ins_mism(input logic [OP_W-1:0] c);
    return (c == OP_INS) || (c == OP_MISM);
  endfunction

endpackage

// ===== rtl/cigar_clip_fold_run_encoder_unit.sv =====
`timescale 1ns / 1ps
// CIGAR run encoder with soft-clip folding. Depends on ccfre_pkg and ccfre_ram.
// A push is taken only in the idle state, and pushes may follow back to back. End of record
// scans the leading and then the trailing clip region, and a pull walks the ops of one run,
// both through the op store's single read port, one op per cycle. A stalled result holds the
// sequencer. Reset clears control state, not the op store.
module cigar_clip_fold_run_encoder_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ccfre_pkg::in_beat_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ccfre_pkg::out_beat_t            out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccfre_pkg::PADDR_W-1:0]   paddr,
  input  logic [ccfre_pkg::PDATA_W-1:0]   pwdata,
  output logic [ccfre_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import ccfre_pkg::*;

  // The sequencer. The idle state is the only one that takes input beats; the
  // scan and pull states walk the op store one entry per cycle, with the read
  // for the next position issued in the same cycle as the check of the current.
  typedef enum logic [6:0] {
    ST_IDLE        = 7'b0000001,
    ST_LEAD        = 7'b0000010,
    ST_TRAIL_START = 7'b0000100,
    ST_TRAIL       = 7'b0001000,
    ST_PULL_FIRST  = 7'b0010000,
    ST_PULL_RUN    = 7'b0100000,
    ST_RESULT      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] op_total_q, op_total_d;
  logic [CNT_W-1:0] lead_q, lead_d;
  logic [CNT_W-1:0] trail_q, trail_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             closed_q, closed_d;
  logic             ovf_q, ovf_d;
  logic             phase_q, phase_d;
  logic [OP_W-1:0]  run_op_q, run_op_d;
  logic             simplify_q;

  out_beat_t pend_q, pend_d;
  out_beat_t out_q;
  logic      out_valid_q;

  logic             in_acc, out_acc, slot_free, cfg_wr;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [OP_W-1:0]  mem_rdata;
  logic [CNT_W-1:0] pos_inc, pos_dec, push_base, run_end;
  logic [OP_W-1:0]  fv_op;
  logic             scan_adv, scan_to_ix;

  // Op store. Only entries written in the current record are ever read.
  ccfre_ram #(
    .Width (OP_W),
    .Depth (MAX_OPS)
  ) u_op_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_data_i.op_char),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Configuration port. Writes land in the access phase; reads are plain.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_SIMPLIFY) begin
      prdata[0] = simplify_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      simplify_q <= 1'b0;
    end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_SIMPLIFY)) begin
      simplify_q <= pwdata[0];
    end
  end

  // Handshakes. The output register frees its slot in the same cycle that its
  // beat is taken, so a finished result can move into it in that same cycle.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pos_inc = pos_q + 1'b1;
  assign pos_dec = pos_q - 1'b1;

  // The op at pos_q as it will be reported: clip regions read as soft clips,
  // and with simplify set the sequence match and mismatch ops read as M.
  always_comb begin
    if ((pos_q < lead_q) || (pos_q >= trail_q)) begin
      fv_op = OP_SOFT;
    end else if (simplify_q && ((mem_rdata == OP_SEQM) || (mem_rdata == OP_MISM))) begin
      fv_op = OP_ALNM;
    end else begin
      fv_op = mem_rdata;
    end
  end

  // Shared step of both boundary scans. In the first phase soft clips are
  // skipped and an insertion or mismatch moves the scan into the second phase,
  // which skips only insertions and mismatches.
  always_comb begin
    scan_adv   = 1'b0;
    scan_to_ix = 1'b0;
    if (!phase_q) begin
      if (mem_rdata == OP_SOFT) begin
        scan_adv = 1'b1;
      end else if (is_ins_mism(mem_rdata)) begin
        scan_adv   = 1'b1;
        scan_to_ix = 1'b1;
      end
    end else if (is_ins_mism(mem_rdata)) begin
      scan_adv = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_total_d = op_total_q;
    lead_d     = lead_q;
    trail_d    = trail_q;
    rd_idx_d   = rd_idx_q;
    pos_d      = pos_q;
    closed_d   = closed_q;
    ovf_d      = ovf_q;
    phase_d    = phase_q;
    run_op_d   = run_op_q;
    pend_d     = pend_q;
    mem_we     = 1'b0;
    mem_waddr  = op_total_q[ADDR_W-1:0];
    mem_raddr  = pos_q[ADDR_W-1:0];
    push_base  = closed_q ? '0 : op_total_q;
    run_end    = pos_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.opcode)
            OPC_PUSH: begin
              // A push after end of record starts a fresh record.
              if (closed_q) begin
                lead_d   = '0;
                trail_d  = '0;
                rd_idx_d = '0;
                closed_d = 1'b0;
                ovf_d    = 1'b0;
              end
              if (push_base < CNT_W'(MAX_OPS)) begin
                mem_we     = 1'b1;
                mem_waddr  = push_base[ADDR_W-1:0];
                op_total_d = push_base + 1'b1;
              end else begin
                op_total_d = push_base;
                ovf_d      = 1'b1;
              end
            end
            OPC_END: begin
              rd_idx_d = '0;
              phase_d  = 1'b0;
              if (op_total_q == '0) begin
                lead_d   = '0;
                trail_d  = '0;
                closed_d = 1'b1;
              end else begin
                pos_d     = '0;
                mem_raddr = '0;
                state_d   = ST_LEAD;
              end
            end
            OPC_PULL: begin
              pend_d = '0;
              if (!closed_q) begin
                state_d = ST_RESULT;
              end else if (op_total_q == '0) begin
                if (rd_idx_q == '0) begin
                  pend_d.run_valid    = 1'b1;
                  pend_d.run_op       = OP_STAR;
                  pend_d.last_run     = 1'b1;
                  pend_d.empty_record = 1'b1;
                  pend_d.overflow     = ovf_q;
                  rd_idx_d            = CNT_W'(1);
                end
                state_d = ST_RESULT;
              end else if (rd_idx_q >= op_total_q) begin
                state_d = ST_RESULT;
              end else begin
                pos_d     = rd_idx_q;
                mem_raddr = rd_idx_q[ADDR_W-1:0];
                state_d   = ST_PULL_FIRST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_LEAD: begin
        if (scan_adv) begin
          if (scan_to_ix) begin
            phase_d = 1'b1;
          end
          if (pos_inc >= op_total_q) begin
            lead_d  = op_total_q;
            state_d = ST_TRAIL_START;
          end else begin
            pos_d     = pos_inc;
            mem_raddr = pos_inc[ADDR_W-1:0];
          end
        end else begin
          lead_d  = pos_q;
          state_d = ST_TRAIL_START;
        end
      end

      ST_TRAIL_START: begin
        phase_d = 1'b0;
        if (op_total_q <= lead_q) begin
          // The whole record is a leading clip.
          trail_d  = '0;
          closed_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          pos_d     = op_total_q - 1'b1;
          mem_raddr = pos_d[ADDR_W-1:0];
          state_d   = ST_TRAIL;
        end
      end

      ST_TRAIL: begin
        if (scan_adv) begin
          if (scan_to_ix) begin
            phase_d = 1'b1;
          end
          if (pos_q <= lead_q) begin
            // The scan has reached the leading clip. Still among soft clips,
            // it runs on through the leading clip to the start; among
            // insertions and mismatches it stops at the leading clip.
            trail_d  = (phase_q || scan_to_ix) ? pos_q : '0;
            closed_d = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            pos_d     = pos_dec;
            mem_raddr = pos_dec[ADDR_W-1:0];
          end
        end else begin
          trail_d  = pos_inc;
          closed_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_PULL_FIRST: begin
        run_op_d = fv_op;
        if (pos_inc >= op_total_q) begin
          run_end                = pos_inc;
          pend_d.run_valid       = 1'b1;
          pend_d.run_count       = RUN_COUNT_W'(run_end - rd_idx_q);
          pend_d.run_op          = fv_op;
          pend_d.last_run        = 1'b1;
          pend_d.empty_record    = 1'b0;
          pend_d.overflow        = ovf_q;
          rd_idx_d               = run_end;
          state_d                = ST_RESULT;
        end else begin
          pos_d     = pos_inc;
          mem_raddr = pos_inc[ADDR_W-1:0];
          state_d   = ST_PULL_RUN;
        end
      end

      ST_PULL_RUN: begin
        if ((fv_op == run_op_q) && (pos_inc < op_total_q)) begin
          pos_d     = pos_inc;
          mem_raddr = pos_inc[ADDR_W-1:0];
        end else begin
          run_end             = (fv_op == run_op_q) ? pos_inc : pos_q;
          pend_d.run_valid    = 1'b1;
          pend_d.run_count    = RUN_COUNT_W'(run_end - rd_idx_q);
          pend_d.run_op       = run_op_q;
          pend_d.last_run     = (run_end >= op_total_q);
          pend_d.empty_record = 1'b0;
          pend_d.overflow     = ovf_q;
          rd_idx_d            = run_end;
          state_d             = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_total_q  <= '0;
      lead_q      <= '0;
      trail_q     <= '0;
      rd_idx_q    <= '0;
      closed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_total_q <= op_total_d;
      lead_q     <= lead_d;
      trail_q    <= trail_d;
      rd_idx_q   <= rd_idx_d;
      closed_q   <= closed_d;
      ovf_q      <= ovf_d;
      if ((state_q == ST_RESULT) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers that are always written before they are used.
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    phase_q  <= phase_d;
    run_op_q <= run_op_d;
    pend_q   <= pend_d;
    if ((state_q == ST_RESULT) && slot_free) begin
      out_q <= pend_q;
    end
  end

  // An accepted pull always takes the sequencer out of the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.opcode == OPC_PULL)) |=> (state_q != ST_IDLE))
    else $error("pull beat did not leave the idle state");

  // The op count never goes past the store capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_total_q <= CNT_W'(MAX_OPS))
    else $error("op count beyond store capacity");

  // Once a record is closed its clip boundaries lie inside the record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> ((lead_q <= op_total_q) && (trail_q <= op_total_q)))
    else $error("clip boundary outside the record");

  // A real run is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.run_valid && !out_q.empty_record) |-> (out_q.run_count != '0))
    else $error("run beat with zero count");

endmodule

// ===== rtl/ccfre_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// It depends on nothing else.
module ccfre_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
